/* sv/voxel_visible_face_mask_defines.svh */
// Assertion macros shared by the voxel face mask RTL.
`ifndef VOXEL_VISIBLE_FACE_MASK_DEFINES_SVH
`define VOXEL_VISIBLE_FACE_MASK_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define VVFM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define VVFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/vvfm_pkg.sv */
// Types, codes and field layout for the voxel visible face mask block.
package vvfm_pkg;

    // Default chunk dimensions.
    localparam int SIZE_X_DEF = 16;
    localparam int SIZE_Y_DEF = 128;
    localparam int SIZE_Z_DEF = 16;

    // Field widths of an item.
    localparam int KIND_W = 2;
    localparam int SIDE_W = 2;
    localparam int PX_W   = 4;
    localparam int PY_W   = 7;
    localparam int PZ_W   = 4;
    localparam int FACE_W = 6;
    localparam int NBR_W  = 4;

    // Input tdata layout: pos_x, pos_y, pos_z, solid_in.
    localparam int PX_LSB    = 0;
    localparam int PY_LSB    = PX_LSB + PX_W;
    localparam int PZ_LSB    = PY_LSB + PY_W;
    localparam int SOLID_BIT = PZ_LSB + PZ_W;
    localparam int S_TDATA_W = 16;
    // Input tuser layout: kind, edge_side.
    localparam int KIND_LSB  = 0;
    localparam int SIDE_LSB  = KIND_LSB + KIND_W;
    localparam int S_TUSER_W = KIND_W + SIDE_W;
    // Output tdata layout: visible_faces, block_solid, zero pad.
    localparam int M_TDATA_W = 8;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_NBR_PRESENT = 1'b0;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_VOX   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    // Edge plane sides, also the neighbour_present bit numbers.
    localparam logic [SIDE_W-1:0] SIDE_XM = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_XP = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_ZM = 2'd2;
    localparam logic [SIDE_W-1:0] SIDE_ZP = 2'd3;

    // Query steps: the block itself, then one per face in mask bit order.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_SELF = 3'd0;
    localparam logic [STEP_W-1:0] STEP_XM   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_YM   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_ZM   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_XP   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_YP   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_ZP   = 3'd6;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_LAST  = 4'b1000
    } t_state;

    // Where the bit for a step comes from.
    typedef enum logic [1:0] {
        SRC_ONE   = 2'd0,
        SRC_CHUNK = 2'd1,
        SRC_EDGE  = 2'd2
    } t_src;

endpackage

/* sv/voxel_visible_face_mask.sv */
// Voxel visible face mask: chunk solid map, neighbour edge planes and face query sequencer.
// Reset: synchronous on i_rst_n; clears control state, then sweeps every address of the chunk map
//   and edge planes to zero them, with tready low.
// Writes (kind 0 and 1) are taken while idle and leave tready high; kind 3 is taken and dropped.
// Query: tready stays low through S_READ and S_LAST until the result is loaded; the
//   single-port chunk map serves the block and its six neighbours one read per cycle.
`include "voxel_visible_face_mask_defines.svh"

module voxel_visible_face_mask #(
    parameter int SIZE_X = vvfm_pkg::SIZE_X_DEF,
    parameter int SIZE_Y = vvfm_pkg::SIZE_Y_DEF,
    parameter int SIZE_Z = vvfm_pkg::SIZE_Z_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Item input.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pos_x[3:0], pos_y[10:4], pos_z[14:11], solid_in[15]
    input  logic [vvfm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // kind[1:0], edge_side[3:2]
    input  logic [vvfm_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // Result output.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // visible_faces[5:0], block_solid[6], zero[7]
    output logic [vvfm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // Configuration.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vvfm_pkg::APB_AW-1:0]    paddr,
    input  logic [vvfm_pkg::APB_DW-1:0]    pwdata,
    output logic [vvfm_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import vvfm_pkg::*;

    // Address bits per axis and coordinate register widths (wide enough for the port field).
    localparam int AX = $clog2(SIZE_X);
    localparam int AY = $clog2(SIZE_Y);
    localparam int AZ = $clog2(SIZE_Z);
    localparam int XW = (AX > PX_W) ? AX : PX_W;
    localparam int YW = (AY > PY_W) ? AY : PY_W;
    localparam int ZW = (AZ > PZ_W) ? AZ : PZ_W;
    localparam int CW_XY = (XW > YW) ? XW : YW;
    localparam int CW = (CW_XY > ZW) ? CW_XY : ZW;
    localparam int AM = (AX > AZ) ? AX : AZ;

    // Chunk map address {z, y, x}; edge address {side, x or z, y}.
    localparam int CHUNK_AW = AX + AY + AZ;
    localparam int EDGE_AW = SIDE_W + AM + AY;
    localparam int CLR_W = (CHUNK_AW > EDGE_AW) ? CHUNK_AW : EDGE_AW;
    localparam int CHUNK_DEPTH = 1 << CHUNK_AW;
    localparam int EDGE_DEPTH = 1 << EDGE_AW;
    localparam int CLR_LAST = (1 << CLR_W) - 1;

    // ---------------------------------------------------------------- state
    t_state r_state, n_state;
    logic [CLR_W-1:0]  r_clr;
    logic [STEP_W-1:0] r_step;
    logic [NBR_W-1:0]  r_present;

    // Latched query.
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [ZW-1:0] r_z;
    logic          r_in_range;
    logic          r_self;
    logic [FACE_W-1:0] r_mask, n_mask;

    // Read in flight.
    logic              r_rd_vld;
    logic [STEP_W-1:0] r_rd_step;
    t_src              r_rd_src;

    // Output register.
    logic              r_out_vld;
    logic [FACE_W-1:0] r_out_faces;
    logic              r_out_solid;

    // Memories and their registered read data.
    logic r_chunk_mem [CHUNK_DEPTH];
    logic r_edge_mem  [EDGE_DEPTH];
    logic r_chunk_q;
    logic r_edge_q;

    // ---------------------------------------------------------------- input decode
    logic [KIND_W-1:0] w_in_kind;
    logic [SIDE_W-1:0] w_in_side;
    logic [XW-1:0]     w_in_x;
    logic [YW-1:0]     w_in_y;
    logic [ZW-1:0]     w_in_z;
    logic              w_in_solid;
    logic              w_in_x_ok, w_in_y_ok, w_in_z_ok;
    logic              w_s_acc;

    assign w_in_kind  = s_axis_tuser[KIND_LSB +: KIND_W];
    assign w_in_side  = s_axis_tuser[SIDE_LSB +: SIDE_W];
    assign w_in_x     = XW'(s_axis_tdata[PX_LSB +: PX_W]);
    assign w_in_y     = YW'(s_axis_tdata[PY_LSB +: PY_W]);
    assign w_in_z     = ZW'(s_axis_tdata[PZ_LSB +: PZ_W]);
    assign w_in_solid = s_axis_tdata[SOLID_BIT];

    assign w_in_x_ok = ({1'b0, w_in_x} < (XW+1)'(SIZE_X));
    assign w_in_y_ok = ({1'b0, w_in_y} < (YW+1)'(SIZE_Y));
    assign w_in_z_ok = ({1'b0, w_in_z} < (ZW+1)'(SIZE_Z));

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_s_acc = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------- step unit
    // One shared inc/dec picks the neighbour coordinate along the step's axis;
    // faces on the chunk boundary go to an edge plane or count as visible outright.
    logic              w_sel_x, w_sel_y, w_sel_z, w_dec;
    logic [CW-1:0]     w_op, w_res;
    logic [XW-1:0]     w_nx;
    logic [YW-1:0]     w_ny;
    logic [ZW-1:0]     w_nz;
    logic              w_x_lo, w_x_hi, w_y_lo, w_y_hi, w_z_lo, w_z_hi;
    logic [SIDE_W-1:0] w_side;
    logic [AM-1:0]     w_plane_a;
    t_src              w_src;
    logic [CHUNK_AW-1:0] w_rd_chunk_addr;
    logic [EDGE_AW-1:0]  w_rd_edge_addr;

    assign w_sel_x = (r_step == STEP_XM) || (r_step == STEP_XP);
    assign w_sel_y = (r_step == STEP_YM) || (r_step == STEP_YP);
    assign w_sel_z = (r_step == STEP_ZM) || (r_step == STEP_ZP);
    assign w_dec   = (r_step == STEP_XM) || (r_step == STEP_YM) || (r_step == STEP_ZM);

    assign w_op  = w_sel_y ? CW'(r_y) : (w_sel_z ? CW'(r_z) : CW'(r_x));
    assign w_res = w_dec ? (w_op - CW'(1)) : (w_op + CW'(1));

    assign w_nx = w_sel_x ? XW'(w_res) : r_x;
    assign w_ny = w_sel_y ? YW'(w_res) : r_y;
    assign w_nz = w_sel_z ? ZW'(w_res) : r_z;

    assign w_x_lo = (r_x == '0);
    assign w_y_lo = (r_y == '0);
    assign w_z_lo = (r_z == '0);
    assign w_x_hi = (r_x == XW'(SIZE_X - 1));
    assign w_y_hi = (r_y == YW'(SIZE_Y - 1));
    assign w_z_hi = (r_z == ZW'(SIZE_Z - 1));

    always_comb begin
        w_side = SIDE_XM;
        w_src  = SRC_CHUNK;
        case (r_step)
            STEP_SELF: begin
                w_src = SRC_CHUNK;
            end
            STEP_XM: begin
                w_side = SIDE_XM;
                if (w_x_lo) begin
                    w_src = r_present[SIDE_XM] ? SRC_EDGE : SRC_ONE;
                end
            end
            STEP_YM: begin
                if (w_y_lo) begin
                    w_src = SRC_ONE;
                end
            end
            STEP_ZM: begin
                w_side = SIDE_ZM;
                if (w_z_lo) begin
                    w_src = r_present[SIDE_ZM] ? SRC_EDGE : SRC_ONE;
                end
            end
            STEP_XP: begin
                w_side = SIDE_XP;
                if (w_x_hi) begin
                    w_src = r_present[SIDE_XP] ? SRC_EDGE : SRC_ONE;
                end
            end
            STEP_YP: begin
                if (w_y_hi) begin
                    w_src = SRC_ONE;
                end
            end
            STEP_ZP: begin
                w_side = SIDE_ZP;
                if (w_z_hi) begin
                    w_src = r_present[SIDE_ZP] ? SRC_EDGE : SRC_ONE;
                end
            end
            default: begin
                w_src = SRC_ONE;
            end
        endcase
    end

    // x planes are indexed by z, z planes by x.
    assign w_plane_a = w_side[1] ? AM'(r_x) : AM'(r_z);
    assign w_rd_chunk_addr = {w_nz[AZ-1:0], w_ny[AY-1:0], w_nx[AX-1:0]};
    assign w_rd_edge_addr  = {w_side, w_plane_a, r_y[AY-1:0]};

    // ---------------------------------------------------------------- memory ports
    logic                w_chunk_we, w_chunk_wd;
    logic [CHUNK_AW-1:0] w_chunk_addr;
    logic                w_edge_we, w_edge_wd;
    logic [EDGE_AW-1:0]  w_edge_addr;
    logic [AM-1:0]       w_wr_plane_a;
    logic                w_wr_edge_ok;

    assign w_wr_plane_a = w_in_side[1] ? AM'(w_in_x) : AM'(w_in_z);
    assign w_wr_edge_ok = w_in_y_ok && (w_in_side[1] ? w_in_x_ok : w_in_z_ok);

    always_comb begin
        w_chunk_we   = 1'b0;
        w_chunk_wd   = 1'b0;
        w_chunk_addr = w_rd_chunk_addr;
        w_edge_we    = 1'b0;
        w_edge_wd    = 1'b0;
        w_edge_addr  = w_rd_edge_addr;
        case (r_state)
            S_CLEAR: begin
                w_chunk_addr = r_clr[CHUNK_AW-1:0];
                w_edge_addr  = r_clr[EDGE_AW-1:0];
                w_chunk_we   = ({1'b0, r_clr} < (CLR_W+1)'(CHUNK_DEPTH));
                w_edge_we    = ({1'b0, r_clr} < (CLR_W+1)'(EDGE_DEPTH));
            end
            S_IDLE: begin
                w_chunk_addr = {w_in_z[AZ-1:0], w_in_y[AY-1:0], w_in_x[AX-1:0]};
                w_chunk_wd   = w_in_solid;
                w_chunk_we   = w_s_acc && (w_in_kind == KIND_VOX)
                               && w_in_x_ok && w_in_y_ok && w_in_z_ok;
                w_edge_addr  = {w_in_side, w_wr_plane_a, w_in_y[AY-1:0]};
                w_edge_wd    = w_in_solid;
                w_edge_we    = w_s_acc && (w_in_kind == KIND_EDGE) && w_wr_edge_ok;
            end
            default: begin
                w_chunk_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_chunk_we) begin
            r_chunk_mem[w_chunk_addr] <= w_chunk_wd;
        end
        r_chunk_q <= r_chunk_mem[w_chunk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_edge_we) begin
            r_edge_mem[w_edge_addr] <= w_edge_wd;
        end
        r_edge_q <= r_edge_mem[w_edge_addr];
    end

    // ---------------------------------------------------------------- read retire
    logic w_rdata, w_vis;
    logic w_out_load;

    assign w_rdata = (r_rd_src == SRC_EDGE) ? r_edge_q : r_chunk_q;
    // A face is visible when the block across it is empty.
    assign w_vis   = (r_rd_src == SRC_ONE) ? 1'b1 : !w_rdata;

    always_comb begin
        n_mask = r_mask;
        if (r_rd_vld && (r_rd_step != STEP_SELF)) begin
            n_mask = r_mask | (FACE_W'(w_vis) << (r_rd_step - STEP_W'(1)));
        end
    end

    assign w_out_load = (r_state == S_LAST) && (!r_out_vld || m_axis_tready);

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == CLR_W'(CLR_LAST)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_s_acc && (w_in_kind == KIND_QUERY)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_step == STEP_ZP) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_step    <= STEP_SELF;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_present <= '0;
        end else begin
            r_state <= n_state;

            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + CLR_W'(1);
            end

            // Issue one read per cycle; the step counter walks self then six faces.
            if (r_state == S_READ) begin
                r_step <= r_step + STEP_W'(1);
            end else begin
                r_step <= STEP_SELF;
            end
            r_rd_vld <= (r_state == S_READ);

            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            if (psel && penable && pwrite && pready
                && (paddr[REG_SEL_BIT] == REG_NBR_PRESENT)) begin
                r_present <= pwdata[NBR_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_x        <= w_in_x;
            r_y        <= w_in_y;
            r_z        <= w_in_z;
            r_in_range <= w_in_x_ok && w_in_y_ok && w_in_z_ok;
            r_mask     <= '0;
        end else begin
            r_mask <= n_mask;
        end

        if (r_state == S_READ) begin
            r_rd_step <= r_step;
            r_rd_src  <= w_src;
        end

        // Out-of-range blocks read as air.
        if (r_rd_vld && (r_rd_step == STEP_SELF)) begin
            r_self <= w_rdata && r_in_range;
        end

        if (w_out_load) begin
            r_out_faces <= r_self ? n_mask : '0;
            r_out_solid <= r_self;
        end
    end

    // ---------------------------------------------------------------- outputs
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = M_TDATA_W'({r_out_solid, r_out_faces});

    assign pready = 1'b1;
    assign prdata = (paddr[REG_SEL_BIT] == REG_NBR_PRESENT) ? APB_DW'(r_present) : '0;

    // ---------------------------------------------------------------- assertions
    logic w_busy;
    assign w_busy = (r_state == S_READ) || (r_state == S_LAST);

    `VVFM_ASSERT_NOW(a_no_accept_in_clear, r_state == S_CLEAR, !s_axis_tready, "accept in clear")
    `VVFM_ASSERT_NOW(a_no_write_in_query, w_busy, !w_chunk_we && !w_edge_we, "write in query")
    `VVFM_ASSERT_NEXT(a_last_after_zp, r_step == STEP_ZP, r_state == S_LAST, "late retire")
    `VVFM_ASSERT_NOW(a_air_no_faces, r_out_vld && !r_out_solid, r_out_faces == '0, "air faces")

endmodule
